// ----- hdl/rm2d_pkg.sv -----
// ----------------------------------------------------------------------------
// rm2d_pkg: shared types and constants for the 2D range-minimum engine
// Grid sizes, table geometry and operation / status / register codes.
// ----------------------------------------------------------------------------
package rm2d_pkg;

  localparam int MAX_ROWS    = 32;
  localparam int MAX_COLS    = 32;
  localparam int LOG_SIZE    = 5;
  localparam int VALUE_WIDTH = 32;

  localparam int LEVELS   = LOG_SIZE + 1;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int LVL_W    = $clog2(LEVELS);
  localparam int CELL_AW  = ROW_W + COL_W;
  localparam int TAB_AW   = 2 * LVL_W + CELL_AW;
  localparam int CNT_W    = 6;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_BUILD = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_ANSWERED = 2'd0,
    ST_REJECTED = 2'd1,
    ST_DONE     = 2'd2
  } status_t;

  localparam logic [0:0] REG_ROWS = 1'b0;
  localparam logic [0:0] REG_COLS = 1'b1;

endpackage

// ----- hdl/range_min_2d_sparse_table.sv -----
// ----------------------------------------------------------------------------
// range_min_2d_sparse_table: 2D sparse-table range-minimum engine
// Loads grid cells, builds a table of power-of-two block minima and answers
// rectangle minimum queries from four overlapping blocks.
// ----------------------------------------------------------------------------
//
// Channel     Signals                                     Dir
// request     in_valid, in_stall, func..cell_value        in
// result      out_valid, out_stall, min_value, status     out
// config      cfg_we, cfg_index, cfg_data                 in
//
// A load or rejected request goes straight to the result stage; a query first
// makes four reads of the single-port table memory, then a compare. A build
// walks every table entry in use, with two reads and a write per entry.
// Reset clears control only; memories hold garbage until written.
// A result waits in the output register; a new request is taken only once
// the previous result has left.
module range_min_2d_sparse_table (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                func,
  input  logic [5:0]                row_a,
  input  logic [5:0]                col_a,
  input  logic [5:0]                row_b,
  input  logic [5:0]                col_b,
  input  logic signed [31:0]        cell_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        min_value,
  output logic [1:0]                status,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [5:0]                cfg_data
);
  import rm2d_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_QRD, S_QCMP, S_BRD0, S_BRD1, S_BWR, S_OUT
  } state_t;

  state_t state;

  // Memories: raw cells and the table of block minima.
  value_t cell_mem [2**CELL_AW];
  value_t tab_mem  [2**TAB_AW];

  logic [CNT_W-1:0] rows, cols;
  logic             ready;

  // Query working registers.
  logic [ROW_W-1:0] q_r1, q_r3;
  logic [COL_W-1:0] q_c1, q_c3;
  logic [LVL_W-1:0] q_i, q_k;
  logic [2:0]       q_n;
  value_t           q_min;

  // Build walk registers.
  logic [LVL_W-1:0] b_i, b_k;
  logic [ROW_W:0]   b_r;
  logic [COL_W:0]   b_c;
  value_t           b_v0;

  // Memory port.
  logic [TAB_AW-1:0] t_addr;
  logic              t_we;
  value_t            t_wdata, t_rdata, c_rdata;
  logic [CELL_AW-1:0] c_raddr;

  function automatic logic [CNT_W-1:0] clamp(input logic [5:0] v, input int mx);
    if (v == '0) return CNT_W'(1);
    if (int'(v) > mx) return CNT_W'(mx);
    return v;
  endfunction

  function automatic logic [LVL_W-1:0] flog(input logic [CNT_W-1:0] v);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int b = 1; b < CNT_W; b++)
      if (v[b]) r = LVL_W'(b);
    if (int'(r) > LOG_SIZE) r = LVL_W'(LOG_SIZE);
    return r;
  endfunction

  function automatic logic [TAB_AW-1:0] slot(input logic [LVL_W-1:0] i,
      input logic [LVL_W-1:0] k, input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
    return {i, k, r, c};
  endfunction

  logic q_ok;
  logic [CNT_W-1:0] q_h, q_w;
  assign q_ok = ready && row_a >= 6'd1 && col_a >= 6'd1 && row_a <= row_b
             && col_a <= col_b && row_b <= rows && col_b <= cols;
  assign q_h  = row_b - row_a + 6'd1;
  assign q_w  = col_b - col_a + 6'd1;

  // Build sizes for the current level pair.
  logic [ROW_W+1:0] b_rs;
  logic [COL_W+1:0] b_cs;
  logic             b_last_c, b_last_r, b_k_end, b_i_end;
  assign b_rs     = (ROW_W+2)'(1) << b_i;
  assign b_cs     = (COL_W+2)'(1) << b_k;
  assign b_last_c = ((COL_W+2)'(b_c) + 1 + b_cs) > (COL_W+2)'(cols);
  assign b_last_r = ((ROW_W+2)'(b_r) + 1 + b_rs) > (ROW_W+2)'(rows);
  // next level exists while 2^(k+1) <= cols
  assign b_k_end  = (int'(b_k) >= LOG_SIZE) || ((b_cs << 1) > (COL_W+2)'(cols));
  assign b_i_end  = (int'(b_i) >= LOG_SIZE) || ((b_rs << 1) > (ROW_W+2)'(rows));

  logic [ROW_W-1:0] b_r_lo, b_r_hi;
  logic [COL_W-1:0] b_c_lo, b_c_hi;
  assign b_r_lo = b_r[ROW_W-1:0];
  assign b_c_lo = b_c[COL_W-1:0];
  assign b_r_hi = b_r_lo + ROW_W'(b_rs >> 1);
  assign b_c_hi = b_c_lo + COL_W'(b_cs >> 1);

  // Table address select.
  always_comb begin
    t_we    = 1'b0;
    t_wdata = b_v0;
    t_addr  = slot(q_i, q_k, q_r1, q_c1);
    c_raddr = {b_r_lo, b_c_lo};
    unique case (state)
      S_QRD: begin
        unique case (q_n[1:0])
          2'd0: t_addr = slot(q_i, q_k, q_r1, q_c1);
          2'd1: t_addr = slot(q_i, q_k, q_r1, q_c3);
          2'd2: t_addr = slot(q_i, q_k, q_r3, q_c1);
          default: t_addr = slot(q_i, q_k, q_r3, q_c3);
        endcase
      end
      S_BRD0: begin
        if (b_i == '0) t_addr = slot('0, b_k - 1'b1, b_r_lo, b_c_lo);
        else           t_addr = slot(b_i - 1'b1, b_k, b_r_lo, b_c_lo);
      end
      S_BRD1: begin
        if (b_i == '0) t_addr = slot('0, b_k - 1'b1, b_r_lo, b_c_hi);
        else           t_addr = slot(b_i - 1'b1, b_k, b_r_hi, b_c_lo);
      end
      S_BWR: begin
        t_addr  = slot(b_i, b_k, b_r_lo, b_c_lo);
        t_we    = 1'b1;
        if (b_i == '0 && b_k == '0) t_wdata = c_rdata;
        else t_wdata = (t_rdata < b_v0) ? t_rdata : b_v0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (t_we) tab_mem[t_addr] <= t_wdata;
    t_rdata <= tab_mem[t_addr];
    c_rdata <= cell_mem[c_raddr];
    if (state == S_IDLE && in_valid && func == FUNC_LOAD && row_a >= 6'd1
        && int'(row_a) <= MAX_ROWS && col_a >= 6'd1 && int'(col_a) <= MAX_COLS)
      cell_mem[{ROW_W'(row_a - 6'd1), COL_W'(col_a - 6'd1)}] <= cell_value;
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ready     <= 1'b0;
      rows      <= clamp(6'd32, MAX_ROWS);
      cols      <= clamp(6'd32, MAX_COLS);
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ROWS) rows <= clamp(cfg_data, MAX_ROWS);
        else                       cols <= clamp(cfg_data, MAX_COLS);
        ready <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (in_valid) begin
          min_value <= '0;
          unique case (func_t'(func))
            FUNC_LOAD: begin
              ready  <= 1'b0;
              status <= ST_DONE;
              state  <= S_OUT;
            end
            FUNC_BUILD: begin
              b_i   <= '0;
              b_k   <= '0;
              b_r   <= '0;
              b_c   <= '0;
              state <= S_BRD0;
            end
            FUNC_QUERY: begin
              if (q_ok) begin
                q_i   <= flog(q_h);
                q_k   <= flog(q_w);
                q_r1  <= ROW_W'(row_a - 6'd1);
                q_c1  <= COL_W'(col_a - 6'd1);
                q_r3  <= ROW_W'(row_b - (CNT_W'(1) << flog(q_h)));
                q_c3  <= COL_W'(col_b - (CNT_W'(1) << flog(q_w)));
                q_n   <= '0;
                state <= S_QRD;
              end else begin
                status <= ST_REJECTED;
                state  <= S_OUT;
              end
            end
            default: begin
              status <= ST_REJECTED;
              state  <= S_OUT;
            end
          endcase
        end
        S_QRD: begin
          // fold the previous read while issuing the next
          if (q_n == 3'd1) q_min <= t_rdata;
          else if (q_n != 3'd0 && t_rdata < q_min) q_min <= t_rdata;
          q_n <= q_n + 3'd1;
          if (q_n == 3'd3) state <= S_QCMP;
        end
        S_QCMP: begin
          min_value <= (t_rdata < q_min) ? t_rdata : q_min;
          status    <= ST_ANSWERED;
          state     <= S_OUT;
        end
        S_BRD0: state <= S_BRD1;
        S_BRD1: begin
          b_v0  <= t_rdata;
          state <= S_BWR;
        end
        S_BWR: begin
          if (!b_last_c) begin
            b_c   <= b_c + 1'b1;
            state <= S_BRD0;
          end else begin
            b_c <= '0;
            if (!b_last_r) begin
              b_r   <= b_r + 1'b1;
              state <= S_BRD0;
            end else begin
              b_r <= '0;
              if (!b_k_end) begin
                b_k   <= b_k + 1'b1;
                state <= S_BRD0;
              end else begin
                b_k <= '0;
                if (!b_i_end) begin
                  b_i   <= b_i + 1'b1;
                  state <= S_BRD0;
                end else begin
                  ready  <= 1'b1;
                  status <= ST_DONE;
                  state  <= S_OUT;
                end
              end
            end
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/rm2d_checker.sv -----
// ----------------------------------------------------------------------------
// rm2d_checker: port-level checks for the range-minimum engine
// Watches handshakes and result codes at the top level.
// ----------------------------------------------------------------------------
module rm2d_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] min_value,
  input logic [1:0]  status
);
  import rm2d_pkg::*;

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(min_value) && $stable(status))
    else $error("stalled result changed");

  // no request taken while a result is pending
  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request accepted with result pending");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("bad status");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_ANSWERED |-> min_value == '0)
    else $error("nonzero value on non-answer");

endmodule

bind range_min_2d_sparse_table rm2d_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .min_value(min_value), .status(status)
);

// ----- bench/tb_range_min_2d_sparse_table.sv -----
// ----------------------------------------------------------------------------
// tb_range_min_2d_sparse_table: self-checking bench for the 2D range-min engine
// Walks a directed table of requests, then random phases over several grid
// sizes. A behavioral predictor keeps its own grid and answers each rectangle
// by a brute-force scan. Every result is checked in order against it, or
// against the expected result that a directed row gives itself.
module tb_range_min_2d_sparse_table;
  timeunit 1ns;
  timeprecision 1ps;
  import rm2d_pkg::*;

  // One expected result.
  typedef struct {
    value_t  mv;
    status_t st;
  } answer_t;

  // One row of the directed table. A row with set_size rewrites both size
  // registers (once the engine is idle) before its request goes out.
  typedef struct {
    bit         set_size;
    logic [5:0] size_r;
    logic [5:0] size_c;
    func_t      op;
    logic [5:0] ra, ca, rb, cb;
    value_t     val;
    bit         typed;
    value_t     t_mv;
    status_t    t_st;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         func = '0;
  logic [5:0]         row_a = '0, col_a = '0, row_b = '0, col_b = '0;
  logic signed [31:0] cell_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] min_value;
  logic [1:0]         status;
  logic               cfg_we = 1'b0;
  logic               cfg_index = 1'b0;
  logic [5:0]         cfg_data = '0;

  range_min_2d_sparse_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .row_a(row_a), .col_a(col_a), .row_b(row_b), .col_b(col_b),
    .cell_value(cell_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .min_value(min_value), .status(status),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest correct run (all builds of the largest
  // grid with heavy receiver stalls fit many times over).
  initial begin
    #60ms;
    $display("range_min_2d_sparse_table: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  // Own copy of the grid, a snapshot taken at each build, sizes and the
  // table-ready flag. A valid query equals the plain minimum of the snapshot.
  value_t     grid[MAX_ROWS][MAX_COLS];
  value_t     built[MAX_ROWS][MAX_COLS];
  bit         ready;
  int         rows_used = 32;
  int         cols_used = 32;

  answer_t    pending[$];
  int         errors = 0;
  int         n_req = 0, n_answered = 0, n_rejected = 0, n_builds = 0;
  int         tx_idle = 0;
  int         rx_idle = 0;

  function automatic int clamp_size(logic [5:0] v, int max);
    if (v == 0) return 1;
    if (v > max) return max;
    return int'(v);
  endfunction

  // Advance the predictor by one accepted request and return its result.
  function automatic answer_t model_request(func_t op, logic [5:0] ra, logic [5:0] ca,
                                            logic [5:0] rb, logic [5:0] cb, value_t val);
    answer_t a;
    value_t  m;
    a.mv = '0;
    a.st = ST_REJECTED;
    case (op)
      FUNC_LOAD: begin
        if (ra >= 1 && ra <= MAX_ROWS && ca >= 1 && ca <= MAX_COLS)
          grid[ra-1][ca-1] = val;
        ready = 1'b0;
        a.st = ST_DONE;
      end
      FUNC_BUILD: begin
        built = grid;
        ready = 1'b1;
        a.st = ST_DONE;
      end
      FUNC_QUERY: begin
        if (ready && ra >= 1 && ca >= 1 && ra <= rb && ca <= cb &&
            rb <= rows_used && cb <= cols_used) begin
          m = built[ra-1][ca-1];
          for (int r = ra - 1; r < rb; r++)
            for (int c = ca - 1; c < cb; c++)
              if (built[r][c] < m) m = built[r][c];
          a.mv = m;
          a.st = ST_ANSWERED;
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  // ------------------------------------------------------------------ drivers
  // Present one request, idling first at random; leave valid high on accept.
  task automatic send(func_t op, logic [5:0] ra, logic [5:0] ca, logic [5:0] rb,
                      logic [5:0] cb, value_t val, bit typed = 0,
                      value_t t_mv = '0, status_t t_st = ST_DONE);
    answer_t a;
    while ($urandom_range(0, 99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    func       <= op;
    row_a      <= ra;
    col_a      <= ca;
    row_b      <= rb;
    col_b      <= cb;
    cell_value <= val;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    a = model_request(op, ra, ca, rb, cb, val);
    if (typed) begin
      a.mv = t_mv;
      a.st = t_st;
    end
    pending.push_back(a);
    n_req++;
    if (op == FUNC_BUILD) n_builds++;
  endtask

  // Drop valid and hold until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Rewrite both size registers while idle.
  task automatic set_size(logic [5:0] r, logic [5:0] c);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_data  <= r;
    @(posedge clk);
    cfg_index <= REG_COLS;
    cfg_data  <= c;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rows_used = clamp_size(r, MAX_ROWS);
    cols_used = clamp_size(c, MAX_COLS);
    ready     = 1'b0;
    @(posedge clk);
  endtask

  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      default: return value_t'($urandom);
    endcase
  endfunction

  // Receiver side: stall at random.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rx_idle);
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected result min_value=%0d status=%0d", $time, min_value, status);
        errors++;
      end else begin
        e = pending.pop_front();
        if (min_value !== e.mv) begin
          $display("%0t: min_value expected %0d actual %0d", $time, e.mv, min_value);
          errors++;
        end
        if (status !== e.st) begin
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
          errors++;
        end
        if (e.st == ST_ANSWERED) n_answered++;
        else if (e.st == ST_REJECTED) n_rejected++;
      end
    end
  end

  // ------------------------------------------------------------ directed table
  function automatic row_t mk(bit sz, int sr, int sc, func_t op, int ra, int ca, int rb,
                              int cb, value_t val, bit typed, value_t t_mv, status_t t_st);
    row_t t;
    t.set_size = sz;
    t.size_r = 6'(sr);
    t.size_c = 6'(sc);
    t.op = op;
    t.ra = 6'(ra);
    t.ca = 6'(ca);
    t.rb = 6'(rb);
    t.cb = 6'(cb);
    t.val = val;
    t.typed = typed;
    t.t_mv = t_mv;
    t.t_st = t_st;
    return t;
  endfunction

  row_t directed[$];

  initial begin
    logic [5:0] sz_r[8] = '{32, 1, 0, 63, 3, 8, 5, 2};
    logic [5:0] sz_c[8] = '{8, 1, 5, 2, 7, 8, 4, 32};
    int p, ra, ca, rb, cb, n_rand;
    bit big;

    // Reset sizes (32 x 32): nothing built yet, out-of-grid loads.
    directed.push_back(mk(0, 0, 0, FUNC_QUERY, 1, 1, 1, 1, 0, 1, 0, ST_REJECTED));
    directed.push_back(mk(0, 0, 0, FUNC_NONE, 63, 63, 63, 63, -1, 1, 0, ST_REJECTED));
    directed.push_back(mk(0, 0, 0, FUNC_LOAD, 0, 1, 0, 0, 5, 1, 0, ST_DONE));
    directed.push_back(mk(0, 0, 0, FUNC_LOAD, 63, 63, 0, 0, -1, 1, 0, ST_DONE));
    directed.push_back(mk(0, 0, 0, FUNC_LOAD, 33, 5, 0, 0, 9, 1, 0, ST_DONE));
    // Zero sizes count as a single cell; extreme values.
    directed.push_back(mk(1, 0, 0, FUNC_LOAD, 1, 1, 0, 0, 32'sh8000_0000, 1, 0, ST_DONE));
    directed.push_back(mk(0, 0, 0, FUNC_BUILD, 0, 0, 0, 0, 0, 1, 0, ST_DONE));
    directed.push_back(mk(0, 0, 0, FUNC_QUERY, 1, 1, 1, 1, 0, 1, 32'sh8000_0000, ST_ANSWERED));
    directed.push_back(mk(0, 0, 0, FUNC_QUERY, 2, 1, 2, 1, 0, 1, 0, ST_REJECTED));
    directed.push_back(mk(0, 0, 0, FUNC_QUERY, 0, 1, 1, 1, 0, 1, 0, ST_REJECTED));
    directed.push_back(mk(0, 0, 0, FUNC_LOAD, 1, 1, 0, 0, 32'sh7fff_ffff, 1, 0, ST_DONE));
    directed.push_back(mk(0, 0, 0, FUNC_QUERY, 1, 1, 1, 1, 0, 1, 0, ST_REJECTED));
    directed.push_back(mk(0, 0, 0, FUNC_BUILD, 0, 0, 0, 0, 0, 1, 0, ST_DONE));
    directed.push_back(mk(0, 0, 0, FUNC_QUERY, 1, 1, 1, 1, 0, 1, 32'sh7fff_ffff, ST_ANSWERED));
    // 2 x 3 grid: inverted corners, then real answers from the predictor.
    directed.push_back(mk(1, 2, 3, FUNC_LOAD, 1, 1, 0, 0, -5, 0, 0, ST_DONE));
    directed.push_back(mk(0, 0, 0, FUNC_LOAD, 1, 2, 0, 0, 7, 0, 0, ST_DONE));
    directed.push_back(mk(0, 0, 0, FUNC_LOAD, 1, 3, 0, 0, 0, 0, 0, ST_DONE));
    directed.push_back(mk(0, 0, 0, FUNC_LOAD, 2, 1, 0, 0, 100, 0, 0, ST_DONE));
    directed.push_back(mk(0, 0, 0, FUNC_LOAD, 2, 2, 0, 0, -100, 0, 0, ST_DONE));
    directed.push_back(mk(0, 0, 0, FUNC_LOAD, 2, 3, 0, 0, 3, 0, 0, ST_DONE));
    directed.push_back(mk(0, 0, 0, FUNC_BUILD, 0, 0, 0, 0, 0, 0, 0, ST_DONE));
    directed.push_back(mk(0, 0, 0, FUNC_QUERY, 2, 1, 1, 3, 0, 1, 0, ST_REJECTED));
    directed.push_back(mk(0, 0, 0, FUNC_QUERY, 1, 3, 2, 2, 0, 1, 0, ST_REJECTED));
    directed.push_back(mk(0, 0, 0, FUNC_QUERY, 1, 1, 2, 3, 0, 0, 0, ST_DONE));
    directed.push_back(mk(0, 0, 0, FUNC_QUERY, 1, 3, 2, 3, 0, 0, 0, ST_DONE));

    ready = 1'b0;
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle = 14;
    rx_idle = 71;
    foreach (directed[i]) begin
      if (directed[i].set_size) set_size(directed[i].size_r, directed[i].size_c);
      send(directed[i].op, directed[i].ra, directed[i].ca, directed[i].rb, directed[i].cb,
           directed[i].val, directed[i].typed, directed[i].t_mv, directed[i].t_st);
    end

    // Random phases: one grid size each, idling profile switched by phase.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin
        tx_idle = 71;
        rx_idle = 14;
      end else if (ph == 6) begin
        tx_idle = 0;
        rx_idle = 0;
      end
      set_size(sz_r[ph], sz_c[ph]);
      big = (rows_used * cols_used > 256);
      // Fill every cell in use before the first build reads it.
      for (int r = 1; r <= rows_used; r++)
        for (int c = 1; c <= cols_used; c++)
          send(FUNC_LOAD, 6'(r), 6'(c), 6'($urandom), 6'($urandom), pick_value());
      send(FUNC_BUILD, 6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom),
           value_t'($urandom));
      n_rand = 60;
      for (int n = 0; n < n_rand; n++) begin
        if (n == 40) drain();  // hold off the sender until all results are in
        p = $urandom_range(0, 99);
        if (!ready && !big && p < 50) begin
          send(FUNC_BUILD, 6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom),
               value_t'($urandom));
        end else if (p < 60) begin
          // well-formed rectangle, often a thin or single-cell one
          ra = $urandom_range(1, rows_used);
          rb = ($urandom_range(0, 3) == 0) ? ra : $urandom_range(ra, rows_used);
          ca = $urandom_range(1, cols_used);
          cb = ($urandom_range(0, 3) == 0) ? ca : $urandom_range(ca, cols_used);
          send(FUNC_QUERY, 6'(ra), 6'(ca), 6'(rb), 6'(cb), value_t'($urandom));
        end else if (p < 75 && !big) begin
          send(FUNC_LOAD, 6'($urandom_range(1, MAX_ROWS)), 6'($urandom_range(1, MAX_COLS)),
               6'($urandom), 6'($urandom), pick_value());
        end else if (p < 92) begin
          // fully random corners: mostly rejected
          send(FUNC_QUERY, 6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom),
               value_t'($urandom));
        end else if (p < 96 && !big) begin
          // load with a row off the grid
          send(FUNC_LOAD, $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63)),
               6'($urandom), 6'($urandom), 6'($urandom), pick_value());
        end else begin
          send(FUNC_NONE, 6'($urandom), 6'($urandom), 6'($urandom), 6'($urandom),
               value_t'($urandom));
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("Sent %0d requests over 8 grid sizes (%0d builds): %0d answered, %0d rejected.",
             n_req, n_builds, n_answered, n_rejected);
    if (errors == 0) begin
      $display("range_min_2d_sparse_table: match");
    end else begin
      $display("range_min_2d_sparse_table: mismatch");
    end
    $finish;
  end

endmodule
